/* hdl/button_click_classifier_top_macros.svh */
// Assertion macros for the button click classifier.
// Included by button_click_classifier_top; no other dependencies.
`ifndef BUTTON_CLICK_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_TOP_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, disabled during reset
`define BCC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bcc check failed");

// next-cycle implication, disabled during reset
`define BCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bcc check failed");

`else

`define BCC_ASSERT_NOW(label, clk, rst, ante, cons)
`define BCC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hdl/bcc_pkg.sv */
// Shared constants for the button click classifier.
// No dependencies; used by button_click_classifier_top.
package bcc_pkg;

   // field widths
   localparam int TIME_BITS_DEF = 32;
   localparam int CMD_BITS      = 2;
   localparam int EV_BITS       = 3;
   localparam int CFG_BITS      = 16;
   localparam int CSR_IDX_BITS  = 3;
   localparam int PHASE_BITS    = 2;

   // commands
   localparam logic [CMD_BITS-1:0] CMD_TICK    = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_PRESS   = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_RELEASE = 2'd2;

   // events
   localparam logic [EV_BITS-1:0] EV_NONE     = 3'd0;
   localparam logic [EV_BITS-1:0] EV_SINGLE   = 3'd1;
   localparam logic [EV_BITS-1:0] EV_DOUBLE   = 3'd2;
   localparam logic [EV_BITS-1:0] EV_LONG     = 3'd3;
   localparam logic [EV_BITS-1:0] EV_LONG_REL = 3'd4;
   localparam logic [EV_BITS-1:0] EV_SHORT    = 3'd5;
   localparam logic [EV_BITS-1:0] EV_BETWEEN  = 3'd6;

   // phases
   localparam logic [PHASE_BITS-1:0] PH_IDLE  = 2'd0;
   localparam logic [PHASE_BITS-1:0] PH_HELD  = 2'd1;
   localparam logic [PHASE_BITS-1:0] PH_REL1  = 2'd2;
   localparam logic [PHASE_BITS-1:0] PH_TWICE = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_CLICK  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_CLICK  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DOUBLE_GAP = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LONG_MIN   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LONG_MAX   = 3'd4;

   // register reset values
   localparam logic [CFG_BITS-1:0] MIN_CLICK_RST  = 16'd30;
   localparam logic [CFG_BITS-1:0] MAX_CLICK_RST  = 16'd500;
   localparam logic [CFG_BITS-1:0] DOUBLE_GAP_RST = 16'd200;
   localparam logic [CFG_BITS-1:0] LONG_MIN_RST   = 16'd2000;
   localparam logic [CFG_BITS-1:0] LONG_MAX_RST   = 16'd8000;

endpackage

/* hdl/button_click_classifier_top.sv */
// Button click classifier: sorts press/release/tick words into click events.
// Depends on bcc_pkg and button_click_classifier_top_macros.svh.
//
//   channel  direction  handshake           payload
//   req_     in         valid / stall       command, time_ms
//   rsp_     out        valid / stall       event_res
//   csr_     in         valid / ready       index, data
//
// One word per cycle while req_stall is low; a word taken passes through the input
// register, then the classify logic into the result register, which drives rsp_.
// Every request word gives exactly one response word.
// req_stall rises only when the input register is full and the result
// register is held by rsp_stall. csr_ready is always high.
// reset is synchronous, active high; it clears phase, times and registers.
`include "button_click_classifier_top_macros.svh"

module button_click_classifier_top #(
   parameter int TIME_BITS = bcc_pkg::TIME_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bcc_pkg::CMD_BITS-1:0]      req_command,
   input  logic [TIME_BITS-1:0]              req_time_ms,
   // response
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bcc_pkg::EV_BITS-1:0]       rsp_event_res,
   // configuration
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bcc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [bcc_pkg::CFG_BITS-1:0]      csr_data
);
   import bcc_pkg::*;

   // configuration registers
   logic [CFG_BITS-1:0] min_click_ff, max_click_ff, double_gap_ff;
   logic [CFG_BITS-1:0] long_min_ff, long_max_ff;

   // input stage
   logic                 s1_valid_ff, s1_valid_in;
   logic [CMD_BITS-1:0]  s1_cmd_ff;
   logic [TIME_BITS-1:0] s1_time_ff;

   // classifier state
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic                  long_seen_ff, long_seen_in;
   logic [TIME_BITS-1:0]  press_time_ff, press_time_in;
   logic [TIME_BITS-1:0]  release_time_ff, release_time_in;

   // result stage
   logic                rsp_valid_ff, rsp_valid_in;
   logic [EV_BITS-1:0]  rsp_event_ff, event_in;

   logic                 out_hold, advance;
   logic [TIME_BITS-1:0] d_press, d_rel;
   logic [TIME_BITS-1:0] min_click_t, max_click_t, double_gap_t, long_min_t, long_max_t;

   // handshake
   assign out_hold  = rsp_valid_ff && rsp_stall;
   assign advance   = s1_valid_ff && !out_hold;
   assign req_stall = s1_valid_ff && out_hold;
   assign csr_ready = 1'b1;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_click_ff  <= MIN_CLICK_RST;
         max_click_ff  <= MAX_CLICK_RST;
         double_gap_ff <= DOUBLE_GAP_RST;
         long_min_ff   <= LONG_MIN_RST;
         long_max_ff   <= LONG_MAX_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_CLICK:  min_click_ff  <= csr_data;
            CSR_MAX_CLICK:  max_click_ff  <= csr_data;
            CSR_DOUBLE_GAP: double_gap_ff <= csr_data;
            CSR_LONG_MIN:   long_min_ff   <= csr_data;
            CSR_LONG_MAX:   long_max_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // thresholds widened to the timestamp width
   assign min_click_t  = TIME_BITS'(min_click_ff);
   assign max_click_t  = TIME_BITS'(max_click_ff);
   assign double_gap_t = TIME_BITS'(double_gap_ff);
   assign long_min_t   = TIME_BITS'(long_min_ff);
   assign long_max_t   = TIME_BITS'(long_max_ff);

   // input register
   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_cmd_ff  <= req_command;
         s1_time_ff <= req_time_ms;
      end
   end

   // wrapping intervals
   assign d_press = s1_time_ff - press_time_ff;
   assign d_rel   = s1_time_ff - release_time_ff;

   // classify the word in the input register
   always_comb begin
      phase_in        = phase_ff;
      long_seen_in    = long_seen_ff;
      press_time_in   = press_time_ff;
      release_time_in = release_time_ff;
      event_in        = EV_NONE;
      unique case (s1_cmd_ff)
         CMD_TICK: begin
            if (phase_ff == PH_HELD) begin
               if (d_press >= long_min_t && d_press < long_max_t && !long_seen_ff) begin
                  long_seen_in = 1'b1;
                  event_in     = EV_LONG;
               end
            end else if (phase_ff == PH_REL1) begin
               if (d_rel < max_click_t && d_rel > double_gap_t) begin
                  phase_in        = PH_IDLE;
                  long_seen_in    = 1'b0;
                  press_time_in   = '0;
                  release_time_in = '0;
                  event_in        = EV_SINGLE;
               end
            end
         end
         CMD_PRESS: begin
            long_seen_in  = 1'b0;
            press_time_in = s1_time_ff;
            if (phase_ff == PH_IDLE) begin
               phase_in = PH_HELD;
            end else if (phase_ff == PH_REL1) begin
               phase_in = PH_TWICE;
            end
         end
         CMD_RELEASE: begin
            unique case (phase_ff)
               PH_IDLE: ;
               PH_HELD: begin
                  if (long_seen_ff) begin
                     phase_in        = PH_IDLE;
                     long_seen_in    = 1'b0;
                     press_time_in   = '0;
                     release_time_in = '0;
                     event_in        = EV_LONG_REL;
                  end else begin
                     phase_in        = PH_REL1;
                     release_time_in = s1_time_ff;
                  end
               end
               PH_REL1: begin
                  release_time_in = s1_time_ff;
               end
               PH_TWICE: begin
                  // second release: judge the hold time, then start over
                  phase_in        = PH_IDLE;
                  long_seen_in    = 1'b0;
                  press_time_in   = '0;
                  release_time_in = '0;
                  priority if (d_press < min_click_t) begin
                     event_in = EV_SHORT;
                  end else if (d_press < max_click_t) begin
                     event_in = EV_DOUBLE;
                  end else if (d_press < long_min_t) begin
                     event_in = EV_BETWEEN;
                  end else begin
                     event_in = EV_NONE;
                  end
               end
            endcase
         end
         default: ;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         long_seen_ff    <= 1'b0;
         press_time_ff   <= '0;
         release_time_ff <= '0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         long_seen_ff    <= long_seen_in;
         press_time_ff   <= press_time_in;
         release_time_ff <= release_time_in;
      end
   end

   // result register
   assign rsp_valid_in = out_hold ? 1'b1 : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_event_ff <= event_in;
      end
   end

   // checks
   `BCC_ASSERT_NOW(a_long_only_held, clock, reset, long_seen_ff, phase_ff == PH_HELD)
   `BCC_ASSERT_NEXT(a_long_rel_idles, clock, reset, advance && event_in == EV_LONG_REL, phase_ff == PH_IDLE && !long_seen_ff)
   `BCC_ASSERT_NEXT(a_word_reaches_out, clock, reset, advance, rsp_valid)

endmodule

/* dv/tb_button_click_classifier_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for button_click_classifier_top: a local model of the
// click classifier predicts one event per request word. Depends on bcc_pkg.
module tb_button_click_classifier_top;
   import bcc_pkg::*;

   localparam logic [CMD_BITS-1:0]     CMD_UNUSED   = 2'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNMAPPED = 3'd7;
   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [CMD_BITS-1:0]     req_command = CMD_TICK;
   logic [31:0]             req_time_ms = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [EV_BITS-1:0]      rsp_event_res;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]     csr_data = '0;

   button_click_classifier_top #(.TIME_BITS(32)) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_time_ms   (req_time_ms),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_event_res (rsp_event_res),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // classifier model state and registers
   logic [PHASE_BITS-1:0] click_phase;
   bit                    long_fired;
   logic [31:0]           press_at;
   logic [31:0]           release_at;
   logic [CFG_BITS-1:0]   min_click, max_click, double_gap, long_min, long_max;

   logic [EV_BITS-1:0] expected_events[$];
   logic [EV_BITS-1:0] oldest_event;
   int mismatches = 0;
   int words_sent = 0;
   int cycle_count = 0;
   int req_idle_pct = 23;
   int rsp_idle_pct = 23;
   int rsp_cycle = 0;
   int rsp_hold_until = 0;
   logic [31:0] cursor_ms = 32'h8000_0000;

   function automatic void clear_gesture();
      click_phase = PH_IDLE;
      long_fired  = 1'b0;
      press_at    = '0;
      release_at  = '0;
   endfunction

   function automatic void load_reset_regs();
      clear_gesture();
      min_click  = MIN_CLICK_RST;
      max_click  = MAX_CLICK_RST;
      double_gap = DOUBLE_GAP_RST;
      long_min   = LONG_MIN_RST;
      long_max   = LONG_MAX_RST;
   endfunction

   function automatic void store_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
      case (idx)
         CSR_MIN_CLICK:  min_click  = val;
         CSR_MAX_CLICK:  max_click  = val;
         CSR_DOUBLE_GAP: double_gap = val;
         CSR_LONG_MIN:   long_min   = val;
         CSR_LONG_MAX:   long_max   = val;
         default: ;
      endcase
   endfunction

   // advance the gesture state by one word and return the event it raises
   function automatic logic [EV_BITS-1:0] classify_word(logic [CMD_BITS-1:0] cmd,
                                                        logic [31:0] now);
      logic [31:0]        span;
      logic [EV_BITS-1:0] ev;
      ev = EV_NONE;
      case (cmd)
         CMD_TICK: begin
            if (click_phase == PH_HELD) begin
               span = now - press_at;
               if (span >= long_min && span < long_max && !long_fired) begin
                  long_fired = 1'b1;
                  ev = EV_LONG;
               end
            end else if (click_phase == PH_REL1) begin
               span = now - release_at;
               if (span < max_click && span > double_gap) begin
                  clear_gesture();
                  ev = EV_SINGLE;
               end
            end
         end
         CMD_PRESS: begin
            long_fired = 1'b0;
            press_at = now;
            if (click_phase == PH_IDLE)
               click_phase = PH_HELD;
            else if (click_phase == PH_REL1)
               click_phase = PH_TWICE;
         end
         CMD_RELEASE: begin
            if (click_phase != PH_IDLE) begin
               release_at = now;
               span = now - press_at;
               if (click_phase == PH_HELD) begin
                  if (long_fired) begin
                     clear_gesture();
                     ev = EV_LONG_REL;
                  end else begin
                     click_phase = PH_REL1;
                  end
               end else if (click_phase == PH_TWICE) begin
                  // second press classified by its hold time
                  clear_gesture();
                  if (span < min_click)
                     ev = EV_SHORT;
                  else if (span < max_click)
                     ev = EV_DOUBLE;
                  else if (span < long_min)
                     ev = EV_BETWEEN;
               end
            end
         end
         default: ;
      endcase
      return ev;
   endfunction

   task automatic report_mismatch(string what, logic [EV_BITS-1:0] got,
                                  logic [EV_BITS-1:0] want);
      if (mismatches < 40)
         $display("MISMATCH %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
      mismatches++;
   endtask

   // receiver: random stalls, plus a long hold-off when a test asks for one
   always @(negedge clock) begin
      rsp_cycle <= rsp_cycle + 1;
      if (rsp_cycle < rsp_hold_until)
         rsp_stall <= 1'b1;
      else
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_events.size() == 0) begin
            report_mismatch("event word with nothing pending", rsp_event_res, EV_NONE);
         end else begin
            oldest_event = expected_events.pop_front();
            if (rsp_event_res !== oldest_event)
               report_mismatch("event_res", rsp_event_res, oldest_event);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_button_click_classifier_top NOT OK");
         $finish;
      end
   end

   // send one request word; returns at the edge where it is taken
   task automatic send_word(logic [CMD_BITS-1:0] cmd, logic [31:0] now);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      expected_events.push_back(classify_word(cmd, now));
      words_sent++;
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_time_ms <= now;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
   endtask

   // drop valid and wait until every pending event has come back
   task automatic drain_events();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_events.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
      drain_events();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (csr_ready !== 1'b1)
         @(posedge clock);
      store_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_all_regs(logic [CFG_BITS-1:0] mn, logic [CFG_BITS-1:0] mx,
                                 logic [CFG_BITS-1:0] gap, logic [CFG_BITS-1:0] lmin,
                                 logic [CFG_BITS-1:0] lmax);
      write_reg(CSR_MIN_CLICK, mn);
      write_reg(CSR_MAX_CLICK, mx);
      write_reg(CSR_DOUBLE_GAP, gap);
      write_reg(CSR_LONG_MIN, lmin);
      write_reg(CSR_LONG_MAX, lmax);
   endtask

   // offset that lands a few ms either side of a threshold
   function automatic logic [31:0] near_mark(logic [CFG_BITS-1:0] mark);
      return {16'd0, mark} + $urandom_range(6) - 3;
   endfunction

   function automatic logic [31:0] pick_span();
      case ($urandom_range(9))
         0:       return $urandom();
         1, 2:    return $urandom_range(100);
         3:       return near_mark(min_click);
         4:       return near_mark(max_click);
         5:       return near_mark(double_gap);
         6:       return near_mark(long_min);
         7:       return near_mark(long_max);
         default: return $urandom_range(70000);
      endcase
   endfunction

   // send a word at base plus a random span; cursor follows it
   task automatic word_after(logic [CMD_BITS-1:0] cmd, logic [31:0] base);
      cursor_ms = base + pick_span();
      send_word(cmd, cursor_ms);
   endtask

   // one well-formed gesture with random timing, or a bit of noise
   task automatic run_gesture();
      logic [31:0] pressed_ms;
      logic [31:0] released_ms;
      int n;
      case ($urandom_range(9))
         0, 1: begin  // single click and the ticks after it
            word_after(CMD_PRESS, cursor_ms);
            word_after(CMD_RELEASE, cursor_ms);
            released_ms = cursor_ms;
            n = $urandom_range(1, 4);
            repeat (n) word_after(CMD_TICK, released_ms);
         end
         2, 3, 4: begin  // double click
            word_after(CMD_PRESS, cursor_ms);
            word_after(CMD_RELEASE, cursor_ms);
            if ($urandom_range(1)) word_after(CMD_TICK, cursor_ms);
            word_after(CMD_PRESS, cursor_ms);
            pressed_ms = cursor_ms;
            if ($urandom_range(1)) word_after(CMD_TICK, pressed_ms);
            word_after(CMD_RELEASE, pressed_ms);
         end
         5, 6: begin  // long hold with ticks measured from the press
            word_after(CMD_PRESS, cursor_ms);
            pressed_ms = cursor_ms;
            n = $urandom_range(2, 6);
            repeat (n) word_after(CMD_TICK, pressed_ms);
            word_after(CMD_RELEASE, pressed_ms);
         end
         default: begin  // noise, unused command included
            n = $urandom_range(1, 4);
            repeat (n) word_after(logic'($urandom_range(3)) ? CMD_UNUSED : CMD_TICK,
                                  cursor_ms);
            repeat (n) word_after(CMD_BITS'($urandom_range(3)), cursor_ms);
         end
      endcase
   endtask

   task automatic run_gestures(int count);
      int target;
      target = words_sent + count;
      while (words_sent < target)
         run_gesture();
   endtask

   // hand-picked words at the reset register values
   task automatic test_directed();
      send_word(CMD_RELEASE, 32'h0000_0000);      // release while idle
      send_word(CMD_UNUSED, 32'hFFFF_FFFF);       // unused command
      send_word(CMD_TICK, 32'h0000_0000);         // tick while idle
      // long press across the timestamp wrap, fires once, then long release
      send_word(CMD_PRESS, 32'hFFFF_FC00);
      send_word(CMD_TICK, 32'hFFFF_FC00 + 32'd1999);
      send_word(CMD_TICK, 32'hFFFF_FC00 + 32'd2000);
      send_word(CMD_TICK, 32'hFFFF_FC00 + 32'd2500);
      send_word(CMD_RELEASE, 32'hFFFF_FC00 + 32'd2600);
      // single click: gap equal to double_gap does nothing, one more fires
      send_word(CMD_PRESS, 32'd1000);
      send_word(CMD_RELEASE, 32'd1100);
      send_word(CMD_TICK, 32'd1300);
      send_word(CMD_TICK, 32'd1301);
      // too short second press, with a tick while pressed twice
      send_word(CMD_PRESS, 32'd5000);
      send_word(CMD_RELEASE, 32'd5050);
      send_word(CMD_PRESS, 32'd5100);
      send_word(CMD_TICK, 32'd5105);
      send_word(CMD_RELEASE, 32'd5110);
      // double click, then a second press between short and long
      send_word(CMD_PRESS, 32'd6000);
      send_word(CMD_RELEASE, 32'd6050);
      send_word(CMD_PRESS, 32'd6100);
      send_word(CMD_RELEASE, 32'd6200);
      send_word(CMD_PRESS, 32'd7000);
      send_word(CMD_RELEASE, 32'd7050);
      send_word(CMD_PRESS, 32'd7100);
      send_word(CMD_RELEASE, 32'd7700);
      // single window missed, release in released-once, repeated press, long 2nd press
      send_word(CMD_PRESS, 32'd12000);
      send_word(CMD_RELEASE, 32'd12100);
      send_word(CMD_TICK, 32'd12700);
      send_word(CMD_RELEASE, 32'd12800);
      send_word(CMD_PRESS, 32'd12900);
      send_word(CMD_PRESS, 32'd12950);
      send_word(CMD_RELEASE, 32'd15050);
      // hold time equal to long_max fires nothing
      send_word(CMD_PRESS, 32'd20000);
      send_word(CMD_TICK, 32'd28000);
      send_word(CMD_RELEASE, 32'd28100);
   endtask

   // random gestures under a series of register settings, extremes included
   task automatic test_config_sweep();
      run_gestures(180);
      write_all_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      run_gestures(150);
      write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_gestures(150);
      write_all_regs(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
      run_gestures(180);
      write_all_regs(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'd0);
      run_gestures(120);
      write_reg(CSR_UNMAPPED, 16'h5A5A);
      repeat (3) begin
         write_all_regs(16'($urandom_range(200)), 16'($urandom_range(100, 1500)),
                        16'($urandom_range(400)), 16'($urandom_range(800, 5000)),
                        16'($urandom()));
         run_gestures(180);
      end
      write_all_regs(MIN_CLICK_RST, MAX_CLICK_RST, DOUBLE_GAP_RST, LONG_MIN_RST,
                     LONG_MAX_RST);
   endtask

   // back to back traffic on both sides
   task automatic test_no_idle();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_gestures(200);
      req_idle_pct = 23;
      rsp_idle_pct = 23;
   endtask

   // receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_backpressure();
      req_idle_pct = 0;
      rsp_hold_until = rsp_cycle + 150;
      run_gestures(40);
      req_idle_pct = 23;
   endtask

   initial begin
      load_reset_regs();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_backpressure();
      test_no_idle();
      test_config_sweep();

      drain_events();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb_button_click_classifier_top OK");
      else
         $display("tb_button_click_classifier_top NOT OK");
      $finish;
   end

endmodule
